// File: design/spse_pkg.sv
// shared types and constants for the sorted pair set engine
// no dependencies
package spse_pkg;

    localparam int SET_DEPTH = 64;
    localparam int CNT_W     = $clog2(SET_DEPTH + 1);
    localparam int KEY_W     = 64;

    localparam logic [31:0] SIGN_BIAS = 32'h8000_0000;

    localparam logic [2:0] FUNC_INSERT   = 3'd0;
    localparam logic [2:0] FUNC_CONTAINS = 3'd1;
    localparam logic [2:0] FUNC_REMOVE   = 3'd2;
    localparam logic [2:0] FUNC_MARK     = 3'd3;
    localparam logic [2:0] FUNC_KEEP     = 3'd4;
    localparam logic [2:0] FUNC_CLEAR    = 3'd5;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [31:0] key_first;
        logic signed [31:0] key_second;
    } t_in;

    typedef struct packed {
        logic               found;
        logic               dropped_full;
        logic [6:0]         member_count;
        logic               is_empty;
        logic signed [31:0] min_first;
        logic signed [31:0] min_second;
        logic signed [31:0] max_first;
        logic signed [31:0] max_second;
    } t_out;

    typedef struct packed {
        logic load_key;
        logic compare;
        logic apply;
        logic keep_step;
        logic keep_done;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic is_keep;
        logic keep_any;
        logic out_block;
    } t_status;

endpackage

// File: design/sorted_pair_set_engine_unit.sv
// top level of the sorted pair set engine
// depends on spse_pkg, spse_ctrl, spse_cells
// Keeps up to SET_DEPTH signed pairs in ascending order in a row of compare
// cells held in flip-flops. One item is worked at a time: insert, contains,
// remove, mark and clear go from accept to result through a parallel
// compare of all cells, a shift or update and a load of the output register.
// Keep marked goes through the compare and then drops the unmarked entries,
// as the cell row deletes the first unmarked entry each cycle. The result
// sits in an output register, and the next beat is taken once it is loaded.
module sorted_pair_set_engine_unit (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  spse_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output spse_pkg::t_out   o_out_data
);

    spse_pkg::t_cmd    cmd;
    spse_pkg::t_status status;

    spse_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    spse_cells u_cells (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

// File: design/spse_ctrl.sv
// controller state machine of the sorted pair set engine
// depends on spse_pkg
module spse_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  spse_pkg::t_status i_status,
    output spse_pkg::t_cmd    o_cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CMP   = 3'd1;
    localparam logic [2:0] S_APPLY = 3'd2;
    localparam logic [2:0] S_KEEP  = 3'd3;
    localparam logic [2:0] S_RESP  = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_key = 1'b1;
                    n_state        = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.compare = 1'b1;
                n_state       = i_status.is_keep ? S_KEEP : S_APPLY;
            end
            S_APPLY: begin
                o_cmd.apply = 1'b1;
                n_state     = S_RESP;
            end
            S_KEEP: begin
                if (i_status.keep_any) begin
                    o_cmd.keep_step = 1'b1;
                end else begin
                    o_cmd.keep_done = 1'b1;
                    n_state         = S_RESP;
                end
            end
            S_RESP: begin
                if (!i_status.out_block) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// File: design/spse_cells.sv
// datapath: row of sorted entry cells with compare, shift and output register
// depends on spse_pkg
module spse_cells (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  spse_pkg::t_in     i_in_data,
    input  spse_pkg::t_cmd    i_cmd,
    output spse_pkg::t_status o_status,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output spse_pkg::t_out    o_out_data
);

    localparam int D = spse_pkg::SET_DEPTH;
    localparam int C = spse_pkg::CNT_W;

    logic [2:0]                r_func;
    logic [spse_pkg::KEY_W-1:0] r_key;
    logic [D-1:0]              r_lt;
    logic [D-1:0]              r_eq;
    logic [spse_pkg::KEY_W-1:0] r_entry [D];
    logic [spse_pkg::KEY_W-1:0] n_entry [D];
    logic [D-1:0]              r_mark;
    logic [D-1:0]              n_mark;
    logic [C-1:0]              r_count;
    logic [C-1:0]              n_count;
    logic                      r_found;
    logic                      r_dropped;
    logic                      n_found;
    logic                      n_dropped;
    logic [D-1:0]              valid;
    logic [D-1:0]              lt;
    logic [D-1:0]              eq;
    logic [D-1:0]              del;
    logic [D-1:0]              cum;
    logic [D-1:0]              last;
    logic                      present;
    logic [spse_pkg::KEY_W-1:0] hi;
    logic [spse_pkg::KEY_W-1:0] lo;
    spse_pkg::t_out            r_out;
    spse_pkg::t_out            n_out;
    logic                      r_out_valid;

    always_comb begin
        logic acc;
        acc = 1'b0;
        for (int i = 0; i < D; i++) begin
            valid[i] = C'(i) < r_count;
            last[i]  = r_count == C'(i + 1);
            lt[i]    = valid[i] && (r_entry[i] < r_key);
            eq[i]    = valid[i] && (r_entry[i] == r_key);
            del[i]   = valid[i] && !r_mark[i];
            acc      = acc | del[i];
            cum[i]   = acc;
        end
    end

    assign present = |r_eq;

    always_comb begin
        n_entry   = r_entry;
        n_mark    = r_mark;
        n_count   = r_count;
        n_found   = r_found;
        n_dropped = r_dropped;
        if (i_cmd.load_key) begin
            n_found   = 1'b0;
            n_dropped = 1'b0;
        end
        if (i_cmd.apply) begin
            unique case (r_func)
                spse_pkg::FUNC_INSERT: begin
                    n_found = present;
                    if (!present) begin
                        if (r_count == C'(D)) begin
                            n_dropped = 1'b1;
                        end else begin
                            for (int i = 0; i < D; i++) begin
                                if (!r_lt[i]) begin
                                    if (i == 0 || r_lt[(i == 0) ? 0 : i - 1]) begin
                                        n_entry[i] = r_key;
                                        n_mark[i]  = 1'b0;
                                    end else begin
                                        n_entry[i] = r_entry[(i == 0) ? 0 : i - 1];
                                        n_mark[i]  = r_mark[(i == 0) ? 0 : i - 1];
                                    end
                                end
                            end
                            n_count = r_count + C'(1);
                        end
                    end
                end
                spse_pkg::FUNC_CONTAINS: n_found = present;
                spse_pkg::FUNC_REMOVE: begin
                    n_found = present;
                    if (present) begin
                        for (int i = 0; i < D; i++) begin
                            if (!r_lt[i]) begin
                                if (i == D - 1) begin
                                    n_mark[i] = 1'b0;
                                end else begin
                                    n_entry[i] = r_entry[(i == D - 1) ? i : i + 1];
                                    n_mark[i]  = r_mark[(i == D - 1) ? i : i + 1];
                                end
                            end
                        end
                        n_count = r_count - C'(1);
                    end
                end
                spse_pkg::FUNC_MARK: begin
                    n_found = present;
                    n_mark  = r_mark | r_eq;
                end
                spse_pkg::FUNC_CLEAR: begin
                    n_count = '0;
                    n_mark  = '0;
                end
                default: ;
            endcase
        end
        if (i_cmd.keep_step) begin
            for (int i = 0; i < D; i++) begin
                if (cum[i]) begin
                    if (i == D - 1) begin
                        n_mark[i] = 1'b0;
                    end else begin
                        n_entry[i] = r_entry[(i == D - 1) ? i : i + 1];
                        n_mark[i]  = r_mark[(i == D - 1) ? i : i + 1];
                    end
                end
            end
            n_count = r_count - C'(1);
        end
        if (i_cmd.keep_done) begin
            n_mark = '0;
        end
    end

    always_comb begin
        hi = '0;
        for (int i = 0; i < D; i++) begin
            hi = hi | (r_entry[i] & {spse_pkg::KEY_W{last[i]}});
        end
        lo = r_entry[0];
        n_out.found        = r_found;
        n_out.dropped_full = r_dropped;
        n_out.member_count = 7'(r_count);
        if (r_count == '0) begin
            n_out.is_empty   = 1'b1;
            n_out.min_first  = '0;
            n_out.min_second = '0;
            n_out.max_first  = '0;
            n_out.max_second = '0;
        end else begin
            n_out.is_empty   = 1'b0;
            n_out.min_first  = lo[63:32] ^ spse_pkg::SIGN_BIAS;
            n_out.min_second = lo[31:0] ^ spse_pkg::SIGN_BIAS;
            n_out.max_first  = hi[63:32] ^ spse_pkg::SIGN_BIAS;
            n_out.max_second = hi[31:0] ^ spse_pkg::SIGN_BIAS;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_key) begin
            r_func <= i_in_data.func;
            r_key  <= {i_in_data.key_first ^ spse_pkg::SIGN_BIAS,
                       i_in_data.key_second ^ spse_pkg::SIGN_BIAS};
        end
        if (i_cmd.compare) begin
            r_lt <= lt;
            r_eq <= eq;
        end
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
        r_entry   <= n_entry;
        r_found   <= n_found;
        r_dropped <= n_dropped;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_mark      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_count <= n_count;
            r_mark  <= n_mark;
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_status.is_keep   = (r_func == spse_pkg::FUNC_KEEP);
    assign o_status.keep_any  = |del;
    assign o_status.out_block = r_out_valid && !i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out;

endmodule

// File: design/spse_checker.sv
// port checker for the sorted pair set engine, bound to the top level
// depends on spse_pkg and sorted_pair_set_engine_unit
module spse_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_valid,
    input logic           o_in_ready,
    input logic           o_out_valid,
    input logic           i_out_ready,
    input spse_pkg::t_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed while stalled");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.is_empty == (o_out_data.member_count == 7'd0)))
        else $error("empty flag disagrees with count");

    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.member_count <= 7'(spse_pkg::SET_DEPTH)))
        else $error("count beyond capacity");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.is_empty |->
            o_out_data.min_first == '0 && o_out_data.max_second == '0 &&
            o_out_data.min_second == '0 && o_out_data.max_first == '0)
        else $error("empty set reports nonzero bounds");

    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("second beat taken while busy");

endmodule

bind sorted_pair_set_engine_unit spse_checker u_spse_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
